FILE: rtl/line_rasterizer_with_pixel_address_unit_defines.svh
// ----------------------------------------------------------------------------
// line rasterizer assertion macros
// shared assertion forms for the checker; clk and rst_n come from the user scope
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_WITH_PIXEL_ADDRESS_UNIT_DEFINES_SVH
`define LINE_RASTERIZER_WITH_PIXEL_ADDRESS_UNIT_DEFINES_SVH

// same-cycle implication
`define LRPA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrpa assertion failed");

// next-cycle implication
`define LRPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrpa assertion failed");

`endif

FILE: rtl/lrpa_pkg.sv
// ----------------------------------------------------------------------------
// lrpa_pkg
// shared types and constants of the line rasterizer
// ----------------------------------------------------------------------------
package lrpa_pkg;

    localparam int ADDR_W     = 32;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COLOR  = 3'd5;

    typedef struct packed {
        logic [15:0]         row_pitch;
        logic [3:0]          pixel_bytes;
        logic signed [12:0]  origin_x;
        logic signed [12:0]  origin_y;
        logic [ADDR_W-1:0]   frame_base;
        logic [COLOR_W-1:0]  line_color;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        row_pitch:   16'd6400,
        pixel_bytes: 4'd4,
        origin_x:    13'sd800,
        origin_y:    13'sd800,
        frame_base:  32'd0,
        line_color:  24'hFFFFFF
    };

endpackage

FILE: rtl/lrpa_req_if.sv
// ----------------------------------------------------------------------------
// lrpa_req_if
// request channel: start a line with two endpoints or tick the next pixel
// ----------------------------------------------------------------------------
interface lrpa_req_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;

    modport source (
        output valid, req_type, x_start, y_start, x_end, y_end,
        input  ready
    );

    modport sink (
        input  valid, req_type, x_start, y_start, x_end, y_end,
        output ready
    );
endinterface

FILE: rtl/lrpa_pix_if.sv
// ----------------------------------------------------------------------------
// lrpa_pix_if
// pixel channel: coordinates, frame-buffer address, color and last flag
// ----------------------------------------------------------------------------
interface lrpa_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_BITS-1:0]      pixel_x;
    logic signed [COORD_BITS-1:0]      pixel_y;
    logic [lrpa_pkg::ADDR_W-1:0]       pixel_address;
    logic [lrpa_pkg::COLOR_W-1:0]      color;
    logic                              last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_address, color, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_address, color, last,
        output ready
    );
endinterface

FILE: rtl/line_rasterizer_with_pixel_address_unit.sv
// ----------------------------------------------------------------------------
// line_rasterizer_with_pixel_address_unit
// bresenham line engine emitting pixels with frame-buffer byte addresses
// ----------------------------------------------------------------------------
// path: an accepted item passes the core pixel register, then the address unit stages, to the output channel
// throughput: one item per clock while the pixel output is not stalled, set by the bresenham step loop
//   in lrpa_core (error compare, minor step and error update in the same cycle)
// the address unit adds two stages (offset products, then base sum)
// reset: config registers to their defaults, no line active, all stages empty
// ----------------------------------------------------------------------------
module line_rasterizer_with_pixel_address_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lrpa_req_if.sink                            req,
    lrpa_pix_if.source                          pix,
    input  logic                                cfg_we,
    input  logic [lrpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lrpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lrpa_pkg::*;

    // configuration registers, to be written only while the block is idle; the block does not enforce it
    cfg_t cfg_reg;

    // core to address unit pixel hand-off
    logic                         px_valid;
    logic signed [COORD_BITS-1:0] px_x;
    logic signed [COORD_BITS-1:0] px_y;
    logic                         px_last;
    logic                         px_ready;

    // register write decode; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_PITCH:   cfg_reg.row_pitch   <= cfg_wdata[15:0];
                CFG_PIXEL_BYTES: cfg_reg.pixel_bytes <= cfg_wdata[3:0];
                CFG_ORIGIN_X:    cfg_reg.origin_x    <= cfg_wdata[12:0];
                CFG_ORIGIN_Y:    cfg_reg.origin_y    <= cfg_wdata[12:0];
                CFG_FRAME_BASE:  cfg_reg.frame_base  <= cfg_wdata[ADDR_W-1:0];
                CFG_LINE_COLOR:  cfg_reg.line_color  <= cfg_wdata[COLOR_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // stepping engine: start sets up the line and emits the first pixel,
    // each tick while a line is active emits the next one
    lrpa_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .px_valid (px_valid),
        .px_x     (px_x),
        .px_y     (px_y),
        .px_last  (px_last),
        .px_ready (px_ready)
    );

    // address unit: base + pitch * screen row + pixel bytes * screen column
    lrpa_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .px_valid (px_valid),
        .px_x     (px_x),
        .px_y     (px_y),
        .px_last  (px_last),
        .px_ready (px_ready),
        .pix      (pix)
    );

endmodule

FILE: rtl/lrpa_core.sv
// ----------------------------------------------------------------------------
// lrpa_core
// bresenham stepping engine: line setup on start, one step per tick
// ----------------------------------------------------------------------------
module lrpa_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lrpa_req_if.sink                     req,
    output logic                         px_valid,
    output logic signed [COORD_BITS-1:0] px_x,
    output logic signed [COORD_BITS-1:0] px_y,
    output logic                         px_last,
    input  logic                         px_ready
);
    import lrpa_pkg::*;

    localparam int EW = COORD_BITS + 3;
    localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    // line state; positions hold the last emitted pixel, error not yet stepped
    logic                         active_reg;
    logic                         major_is_y_reg;
    logic                         minor_neg_reg;
    logic signed [COORD_BITS-1:0] major_pos_reg;
    logic signed [COORD_BITS-1:0] minor_pos_reg;
    logic [COORD_BITS-1:0]        major_span_reg;
    logic [COORD_BITS-1:0]        minor_span_reg;
    logic signed [EW-1:0]         err_reg;
    logic [COORD_BITS-1:0]        steps_reg;

    logic                         px_valid_reg;
    logic signed [COORD_BITS-1:0] px_x_reg;
    logic signed [COORD_BITS-1:0] px_y_reg;
    logic                         px_last_reg;

    logic accept;
    logic do_start;
    logic do_tick;

    // setup terms
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]          ax_w;
    logic [COORD_BITS:0]          ay_w;
    logic [COORD_BITS-1:0]        ax;
    logic [COORD_BITS-1:0]        ay;
    logic                         st_major_y;
    logic signed [COORD_BITS:0]   md;
    logic signed [COORD_BITS:0]   nd;
    logic                         st_swap;
    logic                         st_minor_neg;
    logic [COORD_BITS-1:0]        st_major_span;
    logic [COORD_BITS-1:0]        st_minor_span;
    logic signed [COORD_BITS-1:0] st_x;
    logic signed [COORD_BITS-1:0] st_y;
    logic signed [EW-1:0]         st_err;

    // step terms
    logic                         step_minor;
    logic signed [COORD_BITS-1:0] adv_minor;
    logic signed [COORD_BITS-1:0] adv_major;
    logic signed [EW-1:0]         adv_err;
    logic [COORD_BITS-1:0]        adv_steps;
    logic signed [EW-1:0]         two_major;
    logic signed [EW-1:0]         two_minor;

    assign req.ready = !px_valid_reg || px_ready;
    assign accept    = req.valid && req.ready;
    assign do_start  = accept && (req.req_type == REQ_START);
    assign do_tick   = accept && (req.req_type == REQ_TICK) && active_reg;

    // line setup
    assign dx   = (COORD_BITS+1)'(req.x_end) - (COORD_BITS+1)'(req.x_start);
    assign dy   = (COORD_BITS+1)'(req.y_end) - (COORD_BITS+1)'(req.y_start);
    assign ax_w = dx[COORD_BITS] ? -dx : dx;
    assign ay_w = dy[COORD_BITS] ? -dy : dy;
    assign ax   = ax_w[COORD_BITS-1:0];
    assign ay   = ay_w[COORD_BITS-1:0];

    assign st_major_y    = !(ax > ay);
    assign md            = st_major_y ? dy : dx;
    assign nd            = st_major_y ? dx : dy;
    assign st_swap       = md[COORD_BITS];
    assign st_minor_neg  = st_swap ? (!nd[COORD_BITS] && (nd != '0)) : nd[COORD_BITS];
    assign st_major_span = st_major_y ? ay : ax;
    assign st_minor_span = st_major_y ? ax : ay;
    assign st_x          = st_swap ? req.x_end : req.x_start;
    assign st_y          = st_swap ? req.y_end : req.y_start;
    assign st_err        = $signed(EW'({st_minor_span, 1'b0}))
                         - $signed(EW'(st_major_span));

    // one bresenham step
    assign two_major  = $signed(EW'({major_span_reg, 1'b0}));
    assign two_minor  = $signed(EW'({minor_span_reg, 1'b0}));
    assign step_minor = err_reg > 0;
    assign adv_minor  = (step_minor && (minor_span_reg != '0))
                      ? (minor_neg_reg ? minor_pos_reg - ONE : minor_pos_reg + ONE)
                      : minor_pos_reg;
    assign adv_major  = major_pos_reg + ONE;
    assign adv_err    = err_reg - (step_minor ? two_major : '0) + two_minor;
    assign adv_steps  = steps_reg - ONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            major_is_y_reg <= 1'b0;
            minor_neg_reg  <= 1'b0;
            major_pos_reg  <= '0;
            minor_pos_reg  <= '0;
            major_span_reg <= '0;
            minor_span_reg <= '0;
            err_reg        <= '0;
            steps_reg      <= '0;
        end
        else if (do_start)
        begin
            active_reg     <= st_major_span != '0;
            major_is_y_reg <= st_major_y;
            minor_neg_reg  <= st_minor_neg;
            major_pos_reg  <= st_major_y ? st_y : st_x;
            minor_pos_reg  <= st_major_y ? st_x : st_y;
            major_span_reg <= st_major_span;
            minor_span_reg <= st_minor_span;
            err_reg        <= st_err;
            steps_reg      <= st_major_span;
        end
        else if (do_tick)
        begin
            active_reg    <= adv_steps != '0;
            major_pos_reg <= adv_major;
            minor_pos_reg <= adv_minor;
            err_reg       <= adv_err;
            steps_reg     <= adv_steps;
        end
    end

    // pixel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            px_valid_reg <= do_start || do_tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_start)
        begin
            px_x_reg    <= st_x;
            px_y_reg    <= st_y;
            px_last_reg <= st_major_span == '0;
        end
        else if (do_tick)
        begin
            px_x_reg    <= major_is_y_reg ? adv_minor : adv_major;
            px_y_reg    <= major_is_y_reg ? adv_major : adv_minor;
            px_last_reg <= adv_steps == '0;
        end
    end

    assign px_valid = px_valid_reg;
    assign px_x     = px_x_reg;
    assign px_y     = px_y_reg;
    assign px_last  = px_last_reg;

endmodule

FILE: rtl/lrpa_addr.sv
// ----------------------------------------------------------------------------
// lrpa_addr
// frame-buffer address unit: offset products, then base sum into the output
// ----------------------------------------------------------------------------
module lrpa_addr #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lrpa_pkg::cfg_t               cfg,
    input  logic                         px_valid,
    input  logic signed [COORD_BITS-1:0] px_x,
    input  logic signed [COORD_BITS-1:0] px_y,
    input  logic                         px_last,
    output logic                         px_ready,
    lrpa_pix_if.source                   pix
);
    import lrpa_pkg::*;

    // screen position width: world coordinate plus 13-bit origin
    localparam int RW  = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;
    localparam int RPW = RW + 17;
    localparam int CPW = RW + 5;

    logic signed [RW-1:0]         row_s;
    logic signed [RW-1:0]         col_s;
    logic signed [RPW-1:0]        row_prod;
    logic signed [CPW-1:0]        col_prod;

    logic                         s2_valid_reg;
    logic signed [COORD_BITS-1:0] s2_x_reg;
    logic signed [COORD_BITS-1:0] s2_y_reg;
    logic                         s2_last_reg;
    logic [ADDR_W-1:0]            s2_row_off_reg;
    logic [ADDR_W-1:0]            s2_col_off_reg;

    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic                         out_last_reg;
    logic [ADDR_W-1:0]            out_addr_reg;
    logic [COLOR_W-1:0]           out_color_reg;
    logic [ADDR_W-1:0]            addr_next;

    logic                         s3_ready;

    assign s3_ready = !out_valid_reg || pix.ready;
    assign px_ready = !s2_valid_reg || s3_ready;

    assign row_s    = RW'(px_y) + RW'($signed(cfg.origin_y));
    assign col_s    = RW'(px_x) + RW'($signed(cfg.origin_x));
    assign row_prod = $signed({1'b0, cfg.row_pitch}) * row_s;
    assign col_prod = $signed({1'b0, cfg.pixel_bytes}) * col_s;

    // product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (px_ready)
        begin
            s2_valid_reg <= px_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (px_ready && px_valid)
        begin
            s2_x_reg       <= px_x;
            s2_y_reg       <= px_y;
            s2_last_reg    <= px_last;
            s2_row_off_reg <= ADDR_W'(row_prod);
            s2_col_off_reg <= ADDR_W'(col_prod);
        end
    end

    // sum stage, wraps modulo 2^32
    assign addr_next = cfg.frame_base + s2_row_off_reg + s2_col_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            out_x_reg     <= s2_x_reg;
            out_y_reg     <= s2_y_reg;
            out_last_reg  <= s2_last_reg;
            out_addr_reg  <= addr_next;
            out_color_reg <= cfg.line_color;
        end
    end

    assign pix.valid         = out_valid_reg;
    assign pix.pixel_x       = out_x_reg;
    assign pix.pixel_y       = out_y_reg;
    assign pix.last          = out_last_reg;
    assign pix.pixel_address = out_addr_reg;
    assign pix.color         = out_color_reg;

endmodule

FILE: rtl/lrpa_checker.sv
// ----------------------------------------------------------------------------
// lrpa_checker
// port-level checks of the line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`include "line_rasterizer_with_pixel_address_unit_defines.svh"

module lrpa_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         req_type,
    input logic signed [COORD_BITS-1:0] x_start,
    input logic signed [COORD_BITS-1:0] y_start,
    input logic signed [COORD_BITS-1:0] x_end,
    input logic signed [COORD_BITS-1:0] y_end,
    input logic                         pix_valid,
    input logic                         pix_ready,
    input logic signed [COORD_BITS-1:0] pix_x,
    input logic signed [COORD_BITS-1:0] pix_y,
    input logic [31:0]                  pix_address,
    input logic                         pix_last
);
    import lrpa_pkg::*;

    logic single_start;

    assign single_start = req_valid && req_ready && (req_type == REQ_START)
                       && (x_start == x_end) && (y_start == y_end);

    // a stalled pixel stays valid and keeps its coordinates, address and last flag
    `LRPA_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable(pix_x) && $stable(pix_y) && $stable(pix_address) && $stable(pix_last))

    // nothing waiting at the output means the request side is open
    `LRPA_ASSERT_IMPL(a_req_open, !(pix_valid && !pix_ready), req_ready)

    // a single-point line comes out as a last pixel at its start point when the output stays ready
    `LRPA_ASSERT_NEXT(a_single_point, single_start ##1 pix_ready ##1 pix_ready, pix_valid && pix_last && (pix_x == $past(x_start, 3)) && (pix_y == $past(y_start, 3)))

endmodule

bind line_rasterizer_with_pixel_address_unit lrpa_checker #(
    .COORD_BITS (COORD_BITS)
) u_lrpa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_type    (req.req_type),
    .x_start     (req.x_start),
    .y_start     (req.y_start),
    .x_end       (req.x_end),
    .y_end       (req.y_end),
    .pix_valid   (pix.valid),
    .pix_ready   (pix.ready),
    .pix_x       (pix.pixel_x),
    .pix_y       (pix.pixel_y),
    .pix_address (pix.pixel_address),
    .pix_last    (pix.last)
);

FILE: tb/tb_line_rasterizer_with_pixel_address_unit.sv
// ----------------------------------------------------------------------------
// tb_line_rasterizer_with_pixel_address_unit
// self-checking bench for the bresenham line engine with pixel addressing:
// a built-in line predictor follows every accepted request, and each pixel
// leaving the block is compared field by field with the oldest predicted one
// ----------------------------------------------------------------------------
module tb_line_rasterizer_with_pixel_address_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import lrpa_pkg::*;

    localparam int COORD_BITS   = 12;
    // pipeline depth of the block in registers; quiesce adds its own margin
    localparam int PIPE_LATENCY = 3;
    // watchdog limit, kept with a wide margin over the slowest legal run
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    // one predicted pixel as it should leave the block
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [ADDR_W-1:0]            addr;
        logic [COLOR_W-1:0]           rgb;
        logic                         last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    lrpa_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
    lrpa_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

    line_rasterizer_with_pixel_address_unit #(
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .pix       (pix_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // pixels predicted but not yet seen at the output
    pixel_t expected_pixels[$];
    int     mismatches = 0;
    int     cycle_count = 0;
    int     stall_left = 0;
    bit     idle_en = 1'b0;

    // predictor copy of the configuration registers
    logic [15:0]        pitch;
    logic [3:0]         bpp;
    int                 org_x;
    int                 org_y;
    logic [ADDR_W-1:0]  fb_base;
    logic [COLOR_W-1:0] line_rgb;

    // predictor copy of the line walker
    bit ln_active;
    bit ln_major_is_y;
    bit ln_minor_neg;
    int ln_major_pos;
    int ln_minor_pos;
    int ln_major_span;
    int ln_minor_span;
    int ln_err;
    int ln_steps_left;

    // ------------------------------------------------------------------------
    // line predictor
    // ------------------------------------------------------------------------

    function automatic void reset_predictor();
        pitch         = CFG_RESET.row_pitch;
        bpp           = CFG_RESET.pixel_bytes;
        org_x         = int'($signed(CFG_RESET.origin_x));
        org_y         = int'($signed(CFG_RESET.origin_y));
        fb_base       = CFG_RESET.frame_base;
        line_rgb      = CFG_RESET.line_color;
        ln_active     = 1'b0;
        ln_major_is_y = 1'b0;
        ln_minor_neg  = 1'b0;
        ln_major_pos  = 0;
        ln_minor_pos  = 0;
        ln_major_span = 0;
        ln_minor_span = 0;
        ln_err        = 0;
        ln_steps_left = 0;
    endfunction

    // only the low bits of each write land in the register
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ROW_PITCH:   pitch    = data[15:0];
            CFG_PIXEL_BYTES: bpp      = data[3:0];
            CFG_ORIGIN_X:    org_x    = int'($signed(data[12:0]));
            CFG_ORIGIN_Y:    org_y    = int'($signed(data[12:0]));
            CFG_FRAME_BASE:  fb_base  = data[31:0];
            CFG_LINE_COLOR:  line_rgb = data[23:0];
            default: ;
        endcase
    endfunction

    // address and color come from the registers as they are at emission
    function automatic void queue_pixel(input bit is_last);
        int     px;
        int     py;
        int     row;
        int     col;
        pixel_t p;
        px     = ln_major_is_y ? ln_minor_pos : ln_major_pos;
        py     = ln_major_is_y ? ln_major_pos : ln_minor_pos;
        row    = py + org_y;
        col    = px + org_x;
        p.x    = px[COORD_BITS-1:0];
        p.y    = py[COORD_BITS-1:0];
        // 32-bit arithmetic wraps like the frame-buffer address does
        p.addr = fb_base + 32'(pitch) * row[31:0] + 32'(bpp) * col[31:0];
        p.rgb  = line_rgb;
        p.last = is_last;
        expected_pixels.push_back(p);
    endfunction

    // one bresenham step along the major axis
    function automatic void step_line();
        if (ln_err > 0)
        begin
            if (ln_minor_span != 0)
                ln_minor_pos += ln_minor_neg ? -1 : 1;
            ln_err -= 2 * ln_major_span;
        end
        ln_err += 2 * ln_minor_span;
        ln_major_pos += 1;
    endfunction

    function automatic void predict_req(input logic kind,
                                        input logic signed [COORD_BITS-1:0] xs, ys, xe, ye);
        int x1;
        int y1;
        int x2;
        int y2;
        int ax;
        int ay;
        int ma1;
        int ma2;
        int mi1;
        int mi2;
        int t;
        if (kind == REQ_START)
        begin
            x1 = xs;
            y1 = ys;
            x2 = xe;
            y2 = ye;
            ax = (x2 > x1) ? x2 - x1 : x1 - x2;
            ay = (y2 > y1) ? y2 - y1 : y1 - y2;
            // ties go to the y axis
            ln_major_is_y = !(ax > ay);
            if (ln_major_is_y)
            begin
                ma1 = y1; ma2 = y2; mi1 = x1; mi2 = x2;
            end
            else
            begin
                ma1 = x1; ma2 = x2; mi1 = y1; mi2 = y2;
            end
            // walk with a rising major coordinate
            if (ma1 > ma2)
            begin
                t = ma1; ma1 = ma2; ma2 = t;
                t = mi1; mi1 = mi2; mi2 = t;
            end
            ln_minor_neg  = mi2 < mi1;
            ln_major_span = ma2 - ma1;
            ln_minor_span = ln_minor_neg ? mi1 - mi2 : mi2 - mi1;
            ln_major_pos  = ma1;
            ln_minor_pos  = mi1;
            ln_err        = 2 * ln_minor_span - ln_major_span;
            ln_steps_left = ln_major_span;
            queue_pixel(ln_steps_left == 0);
            ln_active = ln_steps_left != 0;
            if (ln_active)
                step_line();
        end
        else if (ln_active)
        begin
            ln_steps_left -= 1;
            queue_pixel(ln_steps_left == 0);
            if (ln_steps_left == 0)
                ln_active = 1'b0;
            else
                step_line();
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // called at a falling edge, returns at the falling edge after acceptance
    // with valid still high so the next item can follow back to back
    task automatic send_req(input logic kind,
                            input logic signed [COORD_BITS-1:0] xs, ys, xe, ye);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.x_start  <= xs;
        req_ch.y_start  <= ys;
        req_ch.x_end    <= xe;
        req_ch.y_end    <= ye;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predict_req(kind, xs, ys, xe, ye);
        @(negedge clk);
    endtask

    task automatic start_line(input logic signed [COORD_BITS-1:0] xs, ys, xe, ye);
        send_req(REQ_START, xs, ys, xe, ye);
    endtask

    // endpoints are don't-care on a tick, so they carry junk
    task automatic send_tick();
        send_req(REQ_TICK, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_tick();
    endtask

    // stop requesting, let every predicted pixel drain, then wait out the pipe
    // in case a stray tick is still in flight
    task automatic quiesce();
        req_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        apply_reg(idx, data);
        @(negedge clk);
    endtask

    // writes every register; unused upper data bits carry junk
    task automatic load_settings(input logic [15:0] rp, input logic [3:0] pb,
                                 input int ox, input int oy,
                                 input logic [31:0] base, input logic [23:0] rgb);
        write_reg(CFG_ROW_PITCH,   {16'($urandom), rp});
        write_reg(CFG_PIXEL_BYTES, {28'($urandom), pb});
        write_reg(CFG_ORIGIN_X,    {19'($urandom), ox[12:0]});
        write_reg(CFG_ORIGIN_Y,    {19'($urandom), oy[12:0]});
        write_reg(CFG_FRAME_BASE,  base);
        write_reg(CFG_LINE_COLOR,  {8'($urandom), rgb});
        cfg_we <= 1'b0;
    endtask

    task automatic load_random_settings();
        logic [3:0] pb;
        // mostly legal pixel sizes, sometimes zero or oversized
        pb = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        load_settings(16'($urandom), pb,
                      int'($urandom_range(0, 8191)) - 4096,
                      int'($urandom_range(0, 8191)) - 4096,
                      $urandom, 24'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // coordinate helpers
    // ------------------------------------------------------------------------

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(input int v);
        if (v < -2048)
            v = -2048;
        if (v > 2047)
            v = 2047;
        return v[COORD_BITS-1:0];
    endfunction

    // full range with the edges weighted up
    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return -12'sd2048;
            1:       return 12'sd2047;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] near_coord(
        input logic signed [COORD_BITS-1:0] c, input int reach);
        return clamp_coord(int'(c) + int'($urandom_range(0, 2 * reach)) - reach);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // ticks with no line, single-point lines, tick after a finished line
    task automatic test_idle_ticks_and_points();
        send_ticks(2);
        start_line(12'sd0, 12'sd0, 12'sd0, 12'sd0);
        start_line(-12'sd2048, 12'sd2047, -12'sd2048, 12'sd2047);
        send_tick();
        quiesce();
    endtask

    // each axis choice and minor direction, endpoint swap, restart mid-line
    task automatic test_line_directions();
        // full-range diagonal: equal spans take y as major, dropped after two ticks
        start_line(-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
        send_ticks(2);
        // shallow, drawn right to left, minor falling after the swap
        start_line(12'sd2, 12'sd0, -12'sd2, 12'sd1);
        send_ticks(4);
        // steep, drawn downward, then one tick past the end
        start_line(12'sd0, 12'sd3, 12'sd1, 12'sd0);
        send_ticks(4);
        // longest horizontal span, left active across the next settings
        start_line(12'sd2047, 12'sd0, -12'sd2048, -12'sd1);
        send_tick();
        quiesce();
    endtask

    // register extremes: wrapping addresses, zero and oversized pixel bytes
    task automatic test_register_extremes();
        load_settings(16'hFFFF, 4'd15, -4096, -4096, 32'hFFFF_FFFF, 24'h000000);
        start_line(-12'sd3, -12'sd2, -12'sd1, -12'sd2);
        send_ticks(2);
        quiesce();
        load_settings(16'h0000, 4'd0, 4095, 4095, 32'h0000_0000, 24'hFFFFFF);
        start_line(12'sd2047, 12'sd2047, 12'sd2045, 12'sd2046);
        send_ticks(2);
        quiesce();
    endtask

    // settings change while a line is half drawn: the rest uses the new ones
    task automatic test_settings_mid_line();
        load_settings(16'd1024, 4'd1, 0, 0, 32'h1000_0000, 24'h123456);
        start_line(12'sd0, 12'sd0, 12'sd3, 12'sd2);
        send_tick();
        quiesce();
        load_settings(16'd640, 4'd8, 100, -100, 32'h8000_0000, 24'hABCDEF);
        send_ticks(2);
        quiesce();
    endtask

    // random lines; stray ticks on an idle engine do not count as items
    task automatic run_random_lines(input int n_items);
        int sent;
        int pick;
        int ticks;
        int d;
        logic signed [COORD_BITS-1:0] xs;
        logic signed [COORD_BITS-1:0] ys;
        logic signed [COORD_BITS-1:0] xe;
        logic signed [COORD_BITS-1:0] ye;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 19);
            xs   = rand_coord();
            ys   = rand_coord();
            if (pick < 14)
            begin
                // short line anywhere on the plane
                xe = near_coord(xs, 12);
                ye = near_coord(ys, 12);
            end
            else if (pick < 17)
            begin
                // axis-aligned or exact diagonal
                d = $urandom_range(0, 10);
                case ($urandom_range(0, 2))
                    0: begin xe = xs; ye = near_coord(ys, 10); end
                    1: begin xe = near_coord(xs, 10); ye = ys; end
                    default:
                    begin
                        xe = clamp_coord(int'(xs) + d);
                        ye = clamp_coord($urandom_range(0, 1) ? int'(ys) + d : int'(ys) - d);
                    end
                endcase
            end
            else
            begin
                // long line, cut short by the next start
                xe = rand_coord();
                ye = rand_coord();
            end
            start_line(xs, ys, xe, ye);
            sent++;
            if (pick >= 17)
                ticks = $urandom_range(0, 5);
            else
            begin
                ticks = ln_active ? ln_steps_left : 0;
                case ($urandom_range(0, 7))
                    0:       ticks = $urandom_range(0, ticks);
                    1:       ticks += $urandom_range(1, 3);
                    default: ;
                endcase
            end
            repeat (ticks)
            begin
                if (ln_active)
                    sent++;
                send_tick();
            end
        end
    endtask

    task automatic test_random_lines();
        for (int phase = 0; phase < 5; phase++)
        begin
            // no idling in the middle phase and in the closing one
            idle_en = (phase != 2) && (phase != 4);
            if (phase == 0)
                load_settings(CFG_RESET.row_pitch, CFG_RESET.pixel_bytes,
                              int'($signed(CFG_RESET.origin_x)),
                              int'($signed(CFG_RESET.origin_y)),
                              CFG_RESET.frame_base, CFG_RESET.line_color);
            else
                load_random_settings();
            run_random_lines(100);
            quiesce();
        end
    endtask

    // ------------------------------------------------------------------------
    // pixel sink: ready drops in random bursts, which start only on idling-enabled cycles
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            pix_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            pix_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            pix_ch.ready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // pixel checker: each accepted pixel against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n === 1'b1 && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected pixel: x=%0d y=%0d addr=%h color=%h last=%b",
                             $signed(pix_ch.pixel_x), $signed(pix_ch.pixel_y),
                             pix_ch.pixel_address, pix_ch.color, pix_ch.last);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pix_ch.pixel_x !== want.x || pix_ch.pixel_y !== want.y ||
                    pix_ch.pixel_address !== want.addr || pix_ch.color !== want.rgb ||
                    pix_ch.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("pixel mismatch: expected x=%0d y=%0d addr=%h color=%h last=%b",
                                 $signed(want.x), $signed(want.y), want.addr, want.rgb,
                                 want.last);
                        $display("                actual   x=%0d y=%0d addr=%h color=%h last=%b",
                                 $signed(pix_ch.pixel_x), $signed(pix_ch.pixel_y),
                                 pix_ch.pixel_address, pix_ch.color, pix_ch.last);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_START;
        req_ch.x_start  = '0;
        req_ch.y_start  = '0;
        req_ch.x_end    = '0;
        req_ch.y_end    = '0;
        reset_predictor();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part runs without idling at first, then with it
        test_idle_ticks_and_points();
        idle_en = 1'b1;
        test_line_directions();
        test_register_extremes();
        test_settings_mid_line();
        test_random_lines();

        // quiesce has drained every prediction; give stray items time to show
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
